// ===== rtl/ppu_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helper functions of the particle update unit
package ppu_pkg;

  localparam int unsigned FT_W      = 16;
  localparam int unsigned TIME_W    = 40;
  localparam int unsigned CRD_W     = 32;
  localparam int unsigned RAMP_W    = 17;
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned NUM_AXES  = 3;
  // velocity times zero-extended frame time
  localparam int unsigned PROD_W    = CRD_W + FT_W + 1;
  // velocity sum before saturation: vel + growth or damping + signed gravity adjustment
  localparam int unsigned WIDE_W    = 38;
  // signed gravity adjustment of the z velocity
  localparam int unsigned GADJ_W    = 20;
  localparam int unsigned INC_W     = 16;
  localparam int unsigned RSUM_W    = RAMP_W + 1;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 40;

  localparam int unsigned S_TDATA_W = 264;
  localparam int unsigned S_TUSER_W = KIND_W;
  localparam int unsigned M_TDATA_W = 264;
  localparam int unsigned M_TUSER_W = 2;

  localparam logic [RAMP_W-1:0] RAMP_MAX   = 17'h1ffff;
  localparam logic [RAMP_W-1:0] FIRE_LIMIT = 17'd24576;  // 6.0 in q5.12
  localparam logic [RAMP_W-1:0] EXPL_LIMIT = 17'd32768;  // 8.0 in q5.12

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_TIME = 1'b0,
    CFG_NOW_TIME   = 1'b1
  } cfg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATIC   = 3'd0,
    KIND_FIRE     = 3'd1,
    KIND_EXPLODE  = 3'd2,
    KIND_EXPLODE2 = 3'd3,
    KIND_BLOB     = 3'd4,
    KIND_BLOB2    = 3'd5,
    KIND_GRAV     = 3'd6,
    KIND_SLOWGRAV = 3'd7
  } kind_e;

  typedef struct packed {
    logic [NUM_AXES-1:0][CRD_W-1:0] pos;
    logic [NUM_AXES-1:0][CRD_W-1:0] vel;
    logic [RAMP_W-1:0]              ramp;
    kind_e                          kind;
    logic [COLOR_W-1:0]             color;
    logic [TIME_W-1:0]              die;
  } rec_in_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][CRD_W-1:0]  pos;
    logic [NUM_AXES-1:0][CRD_W-1:0]  vel;
    logic [NUM_AXES-1:0][PROD_W-1:0] prod;
    logic [RSUM_W-1:0]               ramp_sum;
    logic signed [GADJ_W-1:0]        gadj;
    kind_e                           kind;
    logic [COLOR_W-1:0]              color;
    logic [TIME_W-1:0]               die;
    logic                            expired;
  } rec_mid_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][CRD_W-1:0] pos;
    logic [NUM_AXES-1:0][CRD_W-1:0] vel;
    logic [RAMP_W-1:0]              ramp;
    logic [COLOR_W-1:0]             color;
    logic [TIME_W-1:0]              die;
    logic                           expired;
    logic                           burnt;
  } rec_out_t;

  // clamp a wide signed sum into the 32 bit range
  function automatic logic [CRD_W-1:0] sat32(input logic [WIDE_W-1:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[WIDE_W-1:CRD_W-1];
    all_zero = ~|v[WIDE_W-1:CRD_W-1];
    if (all_one || all_zero) begin
      return v[CRD_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7fff_ffff;
    end
  endfunction

  // palette color of each ramp step, per ramp kind
  function automatic logic [COLOR_W-1:0] ramp_color(input kind_e k, input logic [2:0] idx);
    logic [COLOR_W-1:0] c;
    c = '0;
    priority if (k == KIND_FIRE) begin
      unique case (idx)
        3'd0:    c = 8'h6d;
        3'd1:    c = 8'h6b;
        3'd2:    c = 8'h06;
        3'd3:    c = 8'h05;
        3'd4:    c = 8'h04;
        3'd5:    c = 8'h03;
        default: c = 8'h00;
      endcase
    end else if (k == KIND_EXPLODE) begin
      unique case (idx)
        3'd0:    c = 8'h6f;
        3'd1:    c = 8'h6d;
        3'd2:    c = 8'h6b;
        3'd3:    c = 8'h69;
        3'd4:    c = 8'h67;
        3'd5:    c = 8'h65;
        3'd6:    c = 8'h63;
        default: c = 8'h61;
      endcase
    end else begin
      unique case (idx)
        3'd0:    c = 8'h6f;
        3'd1:    c = 8'h6e;
        3'd2:    c = 8'h6d;
        3'd3:    c = 8'h6c;
        3'd4:    c = 8'h6b;
        3'd5:    c = 8'h6a;
        3'd6:    c = 8'h68;
        default: c = 8'h66;
      endcase
    end
    return c;
  endfunction

endpackage

// ===== rtl/ppu_mul_stg.sv =====
`timescale 1ns / 1ps
// first compute stage: velocity products, ramp step, gravity term, expiry test
module ppu_mul_stg
  import ppu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  rec_in_t             rec_i,
  input  logic [FT_W-1:0]     ft_i,
  input  logic [TIME_W-1:0]   now_i,
  output logic                vld_o,
  output rec_mid_t            mid_o
);

  logic            vld_q;
  rec_mid_t        mid_d, mid_q;
  logic [19:0]     ft5;    // ft * 5
  logic [19:0]     ft15;   // ft * 15
  logic [21:0]     ft25;   // ft * 25
  logic [16:0]     grav;   // ft * 5 / 8
  logic [18:0]     grav10; // ft * 25 / 4
  logic [INC_W-1:0] inc;

  always_comb begin
    ft5    = {4'b0, ft_i} + {2'b0, ft_i, 2'b0};
    ft15   = {ft_i, 4'b0} - {4'b0, ft_i};
    ft25   = {2'b0, ft5} + {ft5, 2'b0};
    grav   = ft5[19:3];
    grav10 = ft25[20:2];

    mid_d.pos     = rec_i.pos;
    mid_d.vel     = rec_i.vel;
    mid_d.kind    = rec_i.kind;
    mid_d.color   = rec_i.color;
    mid_d.die     = rec_i.die;
    mid_d.expired = rec_i.die < now_i;

    for (int i = 0; i < NUM_AXES; i++) begin
      mid_d.prod[i] = $signed(rec_i.vel[i]) * $signed({1'b0, ft_i});
    end

    unique case (rec_i.kind)
      KIND_FIRE: begin
        inc        = ft5[19:4];
        mid_d.gadj = $signed({3'b0, grav});
      end
      KIND_EXPLODE: begin
        inc        = ft5[18:3];
        mid_d.gadj = -$signed({1'b0, grav10});
      end
      KIND_EXPLODE2: begin
        inc        = ft15[19:4];
        mid_d.gadj = -$signed({1'b0, grav10});
      end
      KIND_BLOB, KIND_BLOB2, KIND_GRAV, KIND_SLOWGRAV: begin
        inc        = '0;
        mid_d.gadj = -$signed({3'b0, grav});
      end
      KIND_STATIC: begin
        inc        = '0;
        mid_d.gadj = '0;
      end
    endcase

    mid_d.ramp_sum = {1'b0, rec_i.ramp} + {2'b0, inc};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q <= mid_d;
    end
  end

  assign vld_o = vld_q;
  assign mid_o = mid_q;

endmodule

// ===== rtl/ppu_sum_stg.sv =====
`timescale 1ns / 1ps
// second compute stage: saturating sums, ramp end test and palette lookup
module ppu_sum_stg
  import ppu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      vld_i,
  input  rec_mid_t  mid_i,
  output logic      vld_o,
  output rec_out_t  out_o
);

  logic                    vld_q;
  rec_out_t                out_d, out_q;
  logic [PROD_W-17:0]      step;   // product / 65536, floored
  logic [PROD_W-15:0]      d14;    // product / 16384, floored
  logic [WIDE_W-1:0]       dv;
  logic [WIDE_W-1:0]       pos_w;
  logic [WIDE_W-1:0]       vel_w;
  logic [RAMP_W-1:0]       ramp_sat;
  logic [RAMP_W-1:0]       limit;
  logic                    has_ramp;
  logic                    burnt;

  always_comb begin
    out_d = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      step  = mid_i.prod[i][PROD_W-1:16];
      d14   = mid_i.prod[i][PROD_W-1:14];
      pos_w = WIDE_W'($signed(mid_i.pos[i])) + WIDE_W'($signed(step));
      unique case (mid_i.kind)
        KIND_EXPLODE, KIND_BLOB: dv = WIDE_W'($signed(d14));
        KIND_EXPLODE2:           dv = -WIDE_W'($signed(step));
        KIND_BLOB2:              dv = (i < 2) ? -WIDE_W'($signed(d14)) : '0;
        KIND_STATIC, KIND_FIRE, KIND_GRAV, KIND_SLOWGRAV: dv = '0;
      endcase
      vel_w = WIDE_W'($signed(mid_i.vel[i])) + dv;
      if (i == NUM_AXES - 1) begin
        vel_w = vel_w + WIDE_W'(mid_i.gadj);
      end
      out_d.pos[i] = sat32(pos_w);
      out_d.vel[i] = sat32(vel_w);
    end

    has_ramp = (mid_i.kind == KIND_FIRE) || (mid_i.kind == KIND_EXPLODE) ||
               (mid_i.kind == KIND_EXPLODE2);
    ramp_sat = mid_i.ramp_sum[RSUM_W-1] ? RAMP_MAX : mid_i.ramp_sum[RAMP_W-1:0];
    limit    = (mid_i.kind == KIND_FIRE) ? FIRE_LIMIT : EXPL_LIMIT;
    burnt    = has_ramp && (ramp_sat >= limit);

    out_d.ramp    = ramp_sat;
    out_d.color   = (has_ramp && !burnt) ? ramp_color(mid_i.kind, ramp_sat[14:12])
                                         : mid_i.color;
    out_d.die     = burnt ? '0 : mid_i.die;
    out_d.burnt   = burnt;
    out_d.expired = 1'b0;

    // an expired record reports only the flag
    if (mid_i.expired) begin
      out_d         = '0;
      out_d.expired = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign vld_o = vld_q;
  assign out_o = out_q;

endmodule

// ===== rtl/particle_physics_update_unit.sv =====
`timescale 1ns / 1ps
// top level of the particle update unit: ports, config registers, pipeline control
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+------------------------------------
//  s_axis    | in        | s_axis_tvalid / tready  | particle record, kind in tuser
//  m_axis    | out       | m_axis_tvalid / tready  | next-frame record, flags in tuser
//  cfg       | in        | cfg_we_i (no wait)      | frame_time (idx 0), now_time (idx 1)
//
//  one item per cycle sustained while m_axis is not stalled; an item passes the input register,
//  multiply stage and sum stage before m_axis_tvalid; the three 32x17 velocity products set the
//  critical path of the middle stage
//  reset clears the valid bits and both config registers; payload registers are not reset
//  a stall on m_axis freezes all three stages together and drops s_axis_tready; a stage
//  holding no item moves on as long as the output register is free or being taken
module particle_physics_update_unit
  import ppu_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, ramp_level, color_index, die_time, zero pad
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic [S_TUSER_W-1:0]  s_axis_tuser,

  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
  // new_ramp_level, new_color_index, new_die_time, zero pad
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  // expired, burnt_out
  output logic [M_TUSER_W-1:0]  m_axis_tuser,

  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // config registers
  logic [FT_W-1:0]   ft_q;
  logic [TIME_W-1:0] now_q;

  // pipeline
  logic      adv;        // whole pipeline moves one step
  logic      in_vld_q;
  rec_in_t   in_rec_d, in_rec_q;
  logic      mid_vld;
  rec_mid_t  mid_rec;
  logic      out_vld;
  rec_out_t  out_rec;

  // config writes, taken at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ft_q  <= '0;
      now_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_TIME: ft_q  <= cfg_wdata_i[FT_W-1:0];
        CFG_NOW_TIME:   now_q <= cfg_wdata_i[TIME_W-1:0];
      endcase
    end
  end

  // stall only when the output register holds an item nobody takes
  assign adv           = !out_vld || m_axis_tready;
  assign s_axis_tready = adv;

  // unpack the incoming item
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      in_rec_d.pos[i] = s_axis_tdata[i*CRD_W +: CRD_W];
      in_rec_d.vel[i] = s_axis_tdata[(NUM_AXES+i)*CRD_W +: CRD_W];
    end
    in_rec_d.ramp  = s_axis_tdata[2*NUM_AXES*CRD_W +: RAMP_W];
    in_rec_d.color = s_axis_tdata[2*NUM_AXES*CRD_W+RAMP_W +: COLOR_W];
    in_rec_d.die   = s_axis_tdata[2*NUM_AXES*CRD_W+RAMP_W+COLOR_W +: TIME_W];
    in_rec_d.kind  = kind_e'(s_axis_tuser);
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s_axis_tvalid) begin
      in_rec_q <= in_rec_d;
    end
  end

  // products, ramp step, gravity, expiry
  ppu_mul_stg u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (in_vld_q),
    .rec_i  (in_rec_q),
    .ft_i   (ft_q),
    .now_i  (now_q),
    .vld_o  (mid_vld),
    .mid_o  (mid_rec)
  );

  // saturating sums, burn-out test, palette lookup; holds the result register
  ppu_sum_stg u_sum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (mid_vld),
    .mid_i  (mid_rec),
    .vld_o  (out_vld),
    .out_o  (out_rec)
  );

  // pack the result item
  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {7'b0, out_rec.die, out_rec.color, out_rec.ramp,
                          out_rec.vel, out_rec.pos};
  assign m_axis_tuser  = {out_rec.burnt, out_rec.expired};

endmodule

// ===== tb/sv/tb_particle_physics_update_unit.sv =====
`timescale 1ns / 1ps
// testbench of the particle update unit: directed and random records checked against a predictor
module tb_particle_physics_update_unit;
  import ppu_pkg::*;

  // zero bits above the die time in both tdata buses
  localparam int unsigned PAD_W     = S_TDATA_W - 6 * CRD_W - RAMP_W - COLOR_W - TIME_W;
  localparam int unsigned RUN_LIMIT = 1_000_000;
  localparam longint      RAMP_CEIL = 131071;
  localparam logic [TIME_W-1:0] TIME_END = 40'hff_ffff_ffff;

  // palette color per whole ramp step, step 0 leftmost
  localparam logic [0:7][7:0] FIRE_STEPS   = {8'h6d, 8'h6b, 8'h06, 8'h05,
                                              8'h04, 8'h03, 8'h00, 8'h00};
  localparam logic [0:7][7:0] BURST_STEPS  = {8'h6f, 8'h6d, 8'h6b, 8'h69,
                                              8'h67, 8'h65, 8'h63, 8'h61};
  localparam logic [0:7][7:0] BURST2_STEPS = {8'h6f, 8'h6e, 8'h6d, 8'h6c,
                                              8'h6b, 8'h6a, 8'h68, 8'h66};

  typedef struct packed {
    logic [NUM_AXES-1:0][CRD_W-1:0] pos;
    logic [NUM_AXES-1:0][CRD_W-1:0] vel;
    logic [RAMP_W-1:0]              ramp;
    kind_e                          kind;
    logic [COLOR_W-1:0]             color;
    logic [TIME_W-1:0]              die;
  } particle_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][CRD_W-1:0] pos;
    logic [NUM_AXES-1:0][CRD_W-1:0] vel;
    logic [RAMP_W-1:0]              ramp;
    logic [COLOR_W-1:0]             color;
    logic [TIME_W-1:0]              die;
    logic                           expired;
    logic                           burnt;
  } next_frame_t;

  // predicts the next-frame record of each accepted particle and checks the results in order
  class particle_update_scoreboard;
    logic [FT_W-1:0]   frame_time;
    logic [TIME_W-1:0] now_time;
    next_frame_t       pending_frames[$];
    int unsigned       frames_seen;
    int unsigned       mismatches;

    function new();
      frame_time  = '0;
      now_time    = '0;
      frames_seen = 0;
      mismatches  = 0;
    endfunction

    task report_mismatch(string what);
      $display("mismatch at result %0d: %s", frames_seen, what);
      mismatches++;
    endtask

    function logic [CRD_W-1:0] clamp_word(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[CRD_W-1:0];
    endfunction

    function next_frame_t advance(particle_t p);
      next_frame_t     nf;
      longint          ft, grav, grav10, inc, ramp, limit;
      longint          pos [NUM_AXES];
      longint          vel [NUM_AXES];
      logic [0:7][7:0] steps;
      bit              has_ramp;
      int              i;
      nf = '0;
      // a record past its death time is freed, nothing else is computed
      if (p.die < now_time) begin
        nf.expired = 1'b1;
        return nf;
      end
      ft       = longint'(frame_time);
      grav     = (ft * 5) >>> 3;
      grav10   = (ft * 25) >>> 2;
      inc      = 0;
      limit    = 0;
      steps    = '0;
      has_ramp = 1'b0;
      // position moves by the old velocity, floor of vel * ft / 65536
      for (i = 0; i < NUM_AXES; i++) begin
        pos[i] = longint'(signed'(p.pos[i]));
        vel[i] = longint'(signed'(p.vel[i]));
        pos[i] = pos[i] + ((vel[i] * ft) >>> 16);
      end
      case (p.kind)
        KIND_FIRE: begin
          inc      = (ft * 5) >>> 4;
          limit    = 6;
          steps    = FIRE_STEPS;
          has_ramp = 1'b1;
          vel[2]   = vel[2] + grav;
        end
        KIND_EXPLODE: begin
          inc      = (ft * 10) >>> 4;
          limit    = 8;
          steps    = BURST_STEPS;
          has_ramp = 1'b1;
          for (i = 0; i < NUM_AXES; i++) vel[i] = vel[i] + ((vel[i] * ft) >>> 14);
          vel[2]   = vel[2] - grav10;
        end
        KIND_EXPLODE2: begin
          inc      = (ft * 15) >>> 4;
          limit    = 8;
          steps    = BURST2_STEPS;
          has_ramp = 1'b1;
          for (i = 0; i < NUM_AXES; i++) vel[i] = vel[i] - ((vel[i] * ft) >>> 16);
          vel[2]   = vel[2] - grav10;
        end
        KIND_BLOB: begin
          for (i = 0; i < NUM_AXES; i++) vel[i] = vel[i] + ((vel[i] * ft) >>> 14);
          vel[2] = vel[2] - grav;
        end
        KIND_BLOB2: begin
          // z is not damped, only pulled down
          for (i = 0; i < 2; i++) vel[i] = vel[i] - ((vel[i] * ft) >>> 14);
          vel[2] = vel[2] - grav;
        end
        KIND_GRAV, KIND_SLOWGRAV: begin
          vel[2] = vel[2] - grav;
        end
        default: ;
      endcase
      nf.ramp  = p.ramp;
      nf.color = p.color;
      nf.die   = p.die;
      if (has_ramp) begin
        ramp = longint'(p.ramp) + inc;
        if (ramp > RAMP_CEIL) ramp = RAMP_CEIL;
        nf.ramp = ramp[RAMP_W-1:0];
        // at or past the burn-out limit: burnt out, color kept
        if (ramp >= limit * 4096) begin
          nf.die   = '0;
          nf.burnt = 1'b1;
        end else begin
          nf.color = steps[ramp[14:12]];
        end
      end
      for (i = 0; i < NUM_AXES; i++) begin
        nf.pos[i] = clamp_word(pos[i]);
        nf.vel[i] = clamp_word(vel[i]);
      end
      return nf;
    endfunction

    function void note_particle(particle_t p);
      pending_frames.push_back(advance(p));
    endfunction

    task compare_field(string name, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task check_result(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] flags);
      next_frame_t want;
      next_frame_t got;
      if (pending_frames.size() == 0) begin
        report_mismatch("result with no particle waiting");
        frames_seen++;
        return;
      end
      want        = pending_frames.pop_front();
      got.pos     = data[3*CRD_W-1:0];
      got.vel     = data[6*CRD_W-1:3*CRD_W];
      got.ramp    = data[6*CRD_W +: RAMP_W];
      got.color   = data[6*CRD_W+RAMP_W +: COLOR_W];
      got.die     = data[6*CRD_W+RAMP_W+COLOR_W +: TIME_W];
      got.expired = flags[0];
      got.burnt   = flags[1];
      compare_field("new_pos_x", got.pos[0], want.pos[0]);
      compare_field("new_pos_y", got.pos[1], want.pos[1]);
      compare_field("new_pos_z", got.pos[2], want.pos[2]);
      compare_field("new_vel_x", got.vel[0], want.vel[0]);
      compare_field("new_vel_y", got.vel[1], want.vel[1]);
      compare_field("new_vel_z", got.vel[2], want.vel[2]);
      compare_field("new_ramp_level", got.ramp, want.ramp);
      compare_field("new_color_index", got.color, want.color);
      compare_field("new_die_time", got.die, want.die);
      compare_field("expired", got.expired, want.expired);
      compare_field("burnt_out", got.burnt, want.burnt);
      frames_seen++;
    endtask
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, ramp_level, color_index, die_time, zero pad
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  // kind
  logic [S_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
  // new_ramp_level, new_color_index, new_die_time, zero pad
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  // expired, burnt_out
  logic [M_TUSER_W-1:0]  m_axis_tuser;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = CFG_FRAME_TIME;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  particle_update_scoreboard sb = new();
  int unsigned cycle_count = 0;
  // items left in a run with no sender gaps
  int unsigned send_quiet  = 0;

  particle_physics_update_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly no gap or a short one, now and then a long one or a quiet stretch
  function automatic int unsigned pick_gap(inout int unsigned quiet);
    int unsigned roll;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // coordinate or velocity: mostly moderate, some full range, some next to the rails
  function automatic logic [CRD_W-1:0] rand_coord();
    int unsigned      pick;
    logic [CRD_W-1:0] raw;
    pick = $urandom_range(0, 9);
    raw  = $urandom;
    if (pick < 6) return $signed(raw) >>> $urandom_range(6, 24);
    if (pick < 9) return raw;
    return raw[0] ? 32'h7fff_ffff - {24'b0, raw[15:8]} : 32'h8000_0000 + {24'b0, raw[15:8]};
  endfunction

  function automatic particle_t random_particle(logic [TIME_W-1:0] now);
    particle_t    p;
    logic [63:0]  raw;
    logic [40:0]  later;
    int unsigned  pick;
    int           i;
    for (i = 0; i < NUM_AXES; i++) begin
      p.pos[i] = rand_coord();
      p.vel[i] = rand_coord();
    end
    // ramps cluster below and around the burn-out points
    pick = $urandom_range(0, 9);
    if (pick < 5) p.ramp = RAMP_W'($urandom_range(0, 36863));
    else if (pick < 8) p.ramp = RAMP_W'($urandom_range(0, 131071));
    else p.ramp = ($urandom_range(0, 1) ? 17'd24576 : 17'd32768)
                  - RAMP_W'($urandom_range(0, 2048));
    p.kind  = kind_e'($urandom_range(0, 7));
    p.color = COLOR_W'($urandom_range(0, 255));
    // most records still alive, some with any death time
    raw = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 15) begin
      p.die = raw[TIME_W-1:0];
    end else begin
      later = {1'b0, now} + {1'b0, raw[TIME_W-1:0] >> $urandom_range(0, 39)};
      p.die = later[TIME_W] ? TIME_END : later[TIME_W-1:0];
    end
    return p;
  endfunction

  function automatic particle_t base_particle(kind_e k);
    particle_t p;
    p.pos   = {32'h0000_3000, 32'hffff_e000, 32'h0000_1000};
    p.vel   = {32'h0000_0c00, 32'hffff_f800, 32'h0000_0400};
    p.ramp  = '0;
    p.kind  = k;
    p.color = 8'h20;
    p.die   = TIME_END;
    return p;
  endfunction

  // one item on s_axis after a random gap; valid stays up if the next item follows at once
  task automatic send_particle(input particle_t p);
    int unsigned gap;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{PAD_W{1'b0}}, p.die, p.color, p.ramp, p.vel, p.pos};
    s_axis_tuser  <= p.kind;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_particle(p);
  endtask

  // hold off the sender until every result is back, then let the pipeline drain
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_frames.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // both registers, only while the block is idle
  task automatic apply_setting(logic [FT_W-1:0] ft, logic [TIME_W-1:0] now);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_FRAME_TIME;
    cfg_wdata_i <= CFG_DATA_W'(ft);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_NOW_TIME;
    cfg_wdata_i <= now;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    sb.frame_time = ft;
    sb.now_time   = now;
  endtask

  // result side: stalls of random length with quiet stretches in between
  initial begin : result_stalls
    int unsigned quiet;
    int unsigned stall;
    quiet = 0;
    forever begin
      stall = pick_gap(quiet);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    particle_t       p;
    int unsigned     phase;
    int unsigned     n;
    logic [FT_W-1:0] ft;
    logic [63:0]     raw;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // longest frame time: saturation, burn-out and the expiry boundary
    apply_setting(16'hffff, 40'd1000);
    p = base_particle(KIND_STATIC);
    p.pos = {3{32'h7fff_ffff}};
    p.vel = {3{32'h7fff_ffff}};
    send_particle(p);
    p.pos = {3{32'h8000_0000}};
    p.vel = {3{32'h8000_0000}};
    send_particle(p);
    // fire gravity pushes a full z velocity over the top
    p = base_particle(KIND_FIRE);
    p.vel[2] = 32'h7fff_ffff;
    send_particle(p);
    // fire ramp ends just short of its limit, then just on it
    p = base_particle(KIND_FIRE);
    p.ramp = 17'd4000;
    send_particle(p);
    p.ramp = 17'd4097;
    send_particle(p);
    p = base_particle(KIND_EXPLODE);
    send_particle(p);
    // ramp sum clamps at its ceiling
    p = base_particle(KIND_EXPLODE2);
    p.ramp = 17'h1ffff;
    p.vel  = {3{32'h8000_0000}};
    send_particle(p);
    p = base_particle(KIND_EXPLODE);
    p.vel = {3{32'h7fff_ffff}};
    send_particle(p);
    p = base_particle(KIND_BLOB);
    p.vel = {3{32'h8000_0000}};
    send_particle(p);
    p = base_particle(KIND_BLOB2);
    p.vel = {3{32'h7fff_ffff}};
    send_particle(p);
    p = base_particle(KIND_GRAV);
    p.vel[2] = 32'h8000_0000;
    send_particle(p);
    p = base_particle(KIND_SLOWGRAV);
    p.vel = '0;
    send_particle(p);
    // expired one step before the current time, alive exactly at it
    p = base_particle(KIND_STATIC);
    p.die = 40'd999;
    send_particle(p);
    p = base_particle(KIND_FIRE);
    p.die = 40'd1000;
    send_particle(p);
    p = base_particle(KIND_EXPLODE2);
    p.color = 8'hff;
    p.die   = '0;
    send_particle(p);
    wait_idle();

    // paused: nothing moves, ramp test and table lookup still apply
    apply_setting('0, '0);
    p = base_particle(KIND_FIRE);
    p.ramp = 17'd24575;
    send_particle(p);
    p.ramp = 17'd24576;
    send_particle(p);
    p = base_particle(KIND_EXPLODE);
    p.ramp = 17'd32767;
    send_particle(p);
    p.ramp = 17'd32768;
    send_particle(p);
    p = base_particle(KIND_EXPLODE2);
    p.ramp = 17'd28672;
    send_particle(p);
    p = base_particle(KIND_STATIC);
    p.die = '0;
    send_particle(p);
    p = base_particle(KIND_BLOB);
    p.pos = {3{32'h7fff_ffff}};
    p.vel = {3{32'h7fff_ffff}};
    send_particle(p);
    p = base_particle(KIND_GRAV);
    p.color = 8'hff;
    p.ramp  = 17'h1ffff;
    send_particle(p);

    // random phases, each under its own frame time and clock
    for (phase = 0; phase < 10; phase++) begin
      wait_idle();
      raw = {$urandom, $urandom};
      ft  = $urandom_range(0, 1) ? FT_W'($urandom_range(1, 4096)) : FT_W'($urandom);
      case (phase)
        0: begin
          ft            = '0;
          raw[39:0]     = '0;
        end
        1: ft = 16'hffff;
        2: ft = 16'd1;
        3: raw[39:0] = TIME_END;
        default: ;
      endcase
      apply_setting(ft, raw[TIME_W-1:0]);
      for (n = 0; n < 190; n++) begin
        // one hold-off mid-phase until everything has come back
        if (phase == 4 && n == 95) wait_idle();
        send_particle(random_particle(sb.now_time));
      end
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_frames.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
